// ===== sv/kms_pkg.sv =====
// Shared types, constants and move tables for the knight shortest-path search core.
`default_nettype none

package kms_pkg;

  localparam int COORD_W = 5;
  localparam int BS_W    = 5;
  localparam int STEPS_W = 8;
  localparam int MOVE_W  = 3;
  localparam int ENTRY_W = 2 * COORD_W + STEPS_W;

  localparam logic [BS_W-1:0]    BOARD_RESET = 5'd8;
  localparam logic [MOVE_W-1:0]  MOVE_LAST   = 3'd7;
  localparam logic [STEPS_W-1:0] STEPS_MAX   = 8'hFF;

  typedef struct packed {
    logic load_query;
    logic clr_step;
    logic seed;
    logic pop;
    logic mark_hit;
    logic issue;
    logic publish;
  } kms_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_ok;
    logic fifo_empty;
    logic target_hit;
    logic move_last;
    logic out_busy;
  } kms_stat_t;

  function automatic logic signed [2:0] move_dr(input logic [MOVE_W-1:0] k);
    logic signed [2:0] d;
    case (k)
      3'd0, 3'd1: d = 3'sd2;
      3'd2, 3'd3: d = -3'sd2;
      3'd4, 3'd5: d = 3'sd1;
      default:    d = -3'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] move_dc(input logic [MOVE_W-1:0] k);
    logic signed [2:0] d;
    case (k)
      3'd0, 3'd2: d = 3'sd1;
      3'd1, 3'd3: d = -3'sd1;
      3'd4, 3'd6: d = 3'sd2;
      default:    d = -3'sd2;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kms_if.sv =====
// Valid/ready channel interfaces for query and result beats.
`default_nettype none

interface kms_in_if;
  import kms_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] start_col;
  logic [COORD_W-1:0] target_row;
  logic [COORD_W-1:0] target_col;

  modport source (output valid, start_row, start_col, target_row, target_col,
                  input ready);
  modport sink   (input valid, start_row, start_col, target_row, target_col,
                  output ready);
endinterface

interface kms_out_if;
  import kms_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [STEPS_W-1:0] steps;

  modport source (output valid, found, steps, input ready);
  modport sink   (input valid, found, steps, output ready);
endinterface

`default_nettype wire

// ===== sv/kms_ctrl.sv =====
// Search sequencer: clear, seed, pop, neighbor expansion and result hand-off.
`default_nettype none

module kms_ctrl import kms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kms_stat_t stat,
  output kms_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_CHECK,
    S_MOVES,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_query = 1'b1;
          state_nxt      = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        if (stat.start_ok) begin
          cmd.seed  = 1'b1;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_POP: begin
        if (stat.fifo_empty) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.target_hit) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          state_nxt = S_MOVES;
        end
      end
      S_MOVES: begin
        cmd.issue = 1'b1;
        if (stat.move_last) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_POP;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kms_dp.sv =====
// Search datapath: board register, visited map, frontier FIFO and result register.
`default_nettype none

module kms_dp import kms_pkg::*; #(
  parameter int MAX_BOARD = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [BS_W-1:0]    cfg_wdata,
  input  logic [COORD_W-1:0] q_start_row,
  input  logic [COORD_W-1:0] q_start_col,
  input  logic [COORD_W-1:0] q_target_row,
  input  logic [COORD_W-1:0] q_target_col,
  input  kms_cmd_t           cmd,
  output kms_stat_t          stat,
  input  logic               res_ready,
  output logic               res_valid,
  output logic               res_found,
  output logic [STEPS_W-1:0] res_steps
);

  localparam int SQUARES = MAX_BOARD * MAX_BOARD;
  localparam int SQ_W    = (SQUARES > 1) ? $clog2(SQUARES) : 1;
  localparam int PTR_W   = SQ_W + 1;
  localparam logic [SQ_W-1:0] SQ_LAST = SQ_W'(SQUARES - 1);

  function automatic logic [SQ_W-1:0] sq_of(input logic [COORD_W-1:0] r,
                                            input logic [COORD_W-1:0] c);
    return SQ_W'((int'(r) - 1) * MAX_BOARD + int'(c) - 1);
  endfunction

  logic [BS_W-1:0]    bs_r;
  logic [COORD_W-1:0] sr_r, sc_r, tr_r, tc_r;
  logic [SQ_W-1:0]    clr_cnt_r;
  logic [PTR_W-1:0]   head_r, tail_r;
  logic [ENTRY_W-1:0] fifo_rd_r;
  logic               vis_rd_r;
  logic               p_valid_r;
  logic [SQ_W-1:0]    p_q_r;
  logic [COORD_W-1:0] p_r_r, p_c_r;
  logic [MOVE_W-1:0]  k_r;
  logic               hit_found_r;
  logic [STEPS_W-1:0] hit_steps_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic [STEPS_W-1:0] out_steps_r;

  logic               visited_mem [SQUARES];
  logic [ENTRY_W-1:0] fifo_mem    [SQUARES];

  logic [COORD_W-1:0] n_eff;
  logic [COORD_W-1:0] cur_r, cur_c;
  logic [STEPS_W-1:0] cur_d, next_d;
  logic signed [2:0]  dr_m, dc_m;
  logic signed [7:0]  dr_x, dc_x, nr_s, nc_s, n_s;
  logic               nb_ok;
  logic [SQ_W-1:0]    nb_q;
  logic               expand;
  logic               vis_we, vis_wdata;
  logic [SQ_W-1:0]    vis_waddr;
  logic               fifo_we;
  logic [SQ_W-1:0]    fifo_waddr;
  logic [ENTRY_W-1:0] fifo_wdata;

  assign n_eff = ({2'b00, bs_r} > 7'(MAX_BOARD)) ? COORD_W'(MAX_BOARD) : bs_r;
  assign n_s   = $signed({3'b000, n_eff});

  assign cur_r  = fifo_rd_r[ENTRY_W-1 -: COORD_W];
  assign cur_c  = fifo_rd_r[STEPS_W +: COORD_W];
  assign cur_d  = fifo_rd_r[STEPS_W-1:0];
  assign next_d = (cur_d == STEPS_MAX) ? STEPS_MAX : cur_d + 8'd1;

  assign dr_m  = move_dr(k_r);
  assign dc_m  = move_dc(k_r);
  assign dr_x  = {{5{dr_m[2]}}, dr_m};
  assign dc_x  = {{5{dc_m[2]}}, dc_m};
  assign nr_s  = $signed({3'b000, cur_r}) + dr_x;
  assign nc_s  = $signed({3'b000, cur_c}) + dc_x;
  assign nb_ok = (nr_s >= 8'sd1) && (nr_s <= n_s) && (nc_s >= 8'sd1) && (nc_s <= n_s);
  assign nb_q  = sq_of(nr_s[COORD_W-1:0], nc_s[COORD_W-1:0]);

  assign expand = p_valid_r && !vis_rd_r;

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_cnt_r;
    vis_wdata = 1'b0;
    if (cmd.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd.seed) begin
      vis_we    = 1'b1;
      vis_waddr = sq_of(sr_r, sc_r);
      vis_wdata = 1'b1;
    end else if (expand) begin
      vis_we    = 1'b1;
      vis_waddr = p_q_r;
      vis_wdata = 1'b1;
    end
  end

  always_comb begin
    fifo_we    = 1'b0;
    fifo_waddr = tail_r[SQ_W-1:0];
    fifo_wdata = {p_r_r, p_c_r, next_d};
    if (cmd.seed) begin
      fifo_we    = 1'b1;
      fifo_waddr = '0;
      fifo_wdata = {sr_r, sc_r, {STEPS_W{1'b0}}};
    end else if (expand) begin
      fifo_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) visited_mem[vis_waddr] <= vis_wdata;
    vis_rd_r <= visited_mem[nb_q];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    if (cmd.pop) fifo_rd_r <= fifo_mem[head_r[SQ_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BOARD_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) bs_r <= cfg_wdata;
      if (cmd.load_query) begin
        head_r <= '0;
        tail_r <= '0;
      end else if (cmd.seed) begin
        tail_r <= PTR_W'(1);
      end else begin
        if (cmd.pop) head_r <= head_r + PTR_W'(1);
        if (expand)  tail_r <= tail_r + PTR_W'(1);
      end
      p_valid_r <= cmd.issue && nb_ok;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      sr_r        <= q_start_row;
      sc_r        <= q_start_col;
      tr_r        <= q_target_row;
      tc_r        <= q_target_col;
      clr_cnt_r   <= '0;
      hit_found_r <= 1'b0;
      hit_steps_r <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + SQ_W'(1);
      if (cmd.mark_hit) begin
        hit_found_r <= 1'b1;
        hit_steps_r <= cur_d;
      end
    end
    if (cmd.pop) begin
      k_r <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + MOVE_W'(1);
    end
    p_q_r <= nb_q;
    p_r_r <= nr_s[COORD_W-1:0];
    p_c_r <= nc_s[COORD_W-1:0];
    if (cmd.publish) begin
      out_found_r <= hit_found_r;
      out_steps_r <= hit_steps_r;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == SQ_LAST);
  assign stat.start_ok   = (sr_r >= 5'd1) && (sr_r <= n_eff) &&
                           (sc_r >= 5'd1) && (sc_r <= n_eff);
  assign stat.fifo_empty = (head_r == tail_r);
  assign stat.target_hit = (cur_r == tr_r) && (cur_c == tc_r);
  assign stat.move_last  = (k_r == MOVE_LAST);
  assign stat.out_busy   = out_valid_r && !res_ready;

  assign res_valid = out_valid_r;
  assign res_found = out_found_r;
  assign res_steps = out_steps_r;

endmodule

`default_nettype wire

// ===== sv/knight_min_steps_bfs_core.sv =====
// Knight shortest-path breadth-first search core, top level.
// Per query, in order: visited-map clear over every square, seed, expansion of each
// square popped, the check of the matching square, and the load of the result beat.
// Throughput: one query at a time; the next query beat is taken once the result
// sits in the output register, so the expansion loop over the frontier sets the rate.
// Reset (rst_n, synchronous): board size 8, sequencer idle, no result pending.
`default_nettype none

module knight_min_steps_bfs_core import kms_pkg::*; #(
  parameter int MAX_BOARD = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  kms_in_if.sink          in_ch,
  kms_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [BS_W-1:0] cfg_wdata
);

  kms_cmd_t  cmd;
  kms_stat_t stat;

  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kms_dp #(
    .MAX_BOARD (MAX_BOARD)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_start_row  (in_ch.start_row),
    .q_start_col  (in_ch.start_col),
    .q_target_row (in_ch.target_row),
    .q_target_col (in_ch.target_col),
    .cmd          (cmd),
    .stat         (stat),
    .res_ready    (out_ch.ready),
    .res_valid    (out_ch.valid),
    .res_found    (out_ch.found),
    .res_steps    (out_ch.steps)
  );

endmodule

`default_nettype wire
